// ----- rtl/eased_parameter_crossfader_assert.svh -----
// Assertion macros for the crossfader
`ifndef EASED_PARAMETER_CROSSFADER_ASSERT_SVH
`define EASED_PARAMETER_CROSSFADER_ASSERT_SVH
`ifndef SYNTHESIS
`define EPC_ASSERT(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define EPC_ASSERT_NR(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define EPC_ASSERT(label, clk, rst_n, prop, msg)
`define EPC_ASSERT_NR(label, clk, prop, msg)
`endif
`endif

// ----- rtl/epc_pkg.sv -----
package epc_pkg;

  localparam int PARAM_COUNT_DEF = 9;
  localparam int VALUE_BITS_DEF  = 16;
  localparam int DUR_BITS        = 15;
  localparam int DELTA_BITS      = 10;
  localparam int Q_BITS          = 17;
  localparam logic [DUR_BITS-1:0] MAX_FADE = 15'd30000;
  localparam logic [Q_BITS-1:0]   Q_ONE    = 17'h10000;

  typedef enum logic [1:0] {
    CMD_TICK  = 2'd0,
    CMD_STAGE = 2'd1,
    CMD_START = 2'd2,
    CMD_NONE  = 2'd3
  } cmd_t;

  typedef struct packed {
    logic [1:0]            cmd;
    logic [3:0]            param_index;
    logic [15:0]           param_value;
    logic [DELTA_BITS-1:0] delta_ms;
    logic [DUR_BITS-1:0]   duration_ms;
    logic                  smooth_easing;
  } in_item_t;

  typedef struct packed {
    logic [15:0]       hue_offset;
    logic [15:0]       hue_spread;
    logic [15:0]       saturation;
    logic [15:0]       lightness;
    logic [15:0]       speed;
    logic [15:0]       density;
    logic [15:0]       scale_value;
    logic [15:0]       wobble;
    logic [15:0]       shape_value;
    logic              fading;
    logic [Q_BITS-1:0] eased_progress;
  } out_item_t;

  typedef enum logic [2:0] {
    ST_IDLE, ST_DIV, ST_EASE1, ST_EASE2, ST_BLEND, ST_DONE
  } state_t;

  // controller -> datapath
  typedef struct packed {
    logic load;     // capture input item and apply stage/start/tick bookkeeping
    logic div_go;   // begin progress division
    logic ease1;    // p*p
    logic ease2;    // p*p*(3-2p)
    logic blend;    // interpolate one parameter
    logic finish;   // settle fade state and build result
  } epc_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic is_tick;  // active tick that needs arithmetic
    logic div_done;
    logic smooth;
    logic blend_last;
  } epc_sts_t;

endpackage

// ----- rtl/eased_parameter_crossfader.sv -----
// Nine-parameter cross-fader. Commands stage a target, start a fade or tick
// time; every accepted item yields one result. Stage, start, unused and idle
// ticks go from ST_IDLE straight to ST_DONE; a tick during a fade first runs
// a 31-step restoring divider for progress, two ease multiply steps when
// smoothstep is on, and one cycle per parameter through the shared
// interpolation multiplier. The result is registered through load_d_r into
// out_data, with out_valid raised alongside; while a result waits under
// out_stall the next item is held at its last cycle. in_stall is high while
// an item is in work.
`include "eased_parameter_crossfader_assert.svh"
module eased_parameter_crossfader #(
  parameter int PARAM_COUNT = epc_pkg::PARAM_COUNT_DEF,
  parameter int VALUE_BITS  = epc_pkg::VALUE_BITS_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  epc_pkg::in_item_t  in_data,
  output logic               out_valid,
  input  logic               out_stall,
  output epc_pkg::out_item_t out_data
);

  epc_pkg::epc_cmd_t  ctl;
  epc_pkg::epc_sts_t  sts;
  epc_pkg::out_item_t result;
  epc_pkg::in_item_t  item_r;
  logic               out_load;

  // hold the accepted transfer for the whole item
  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) item_r <= in_data;
  end

  epc_pkg::in_item_t item_use;
  assign item_use = ctl.load ? in_data : item_r;

  epc_ctrl u_ctrl (
    .clk, .rst_n, .in_valid, .in_stall, .out_valid, .out_stall,
    .sts, .ctl, .out_load
  );

  epc_datapath #(.PARAM_COUNT(PARAM_COUNT), .VALUE_BITS(VALUE_BITS)) u_dp (
    .clk, .rst_n, .item(item_use), .ctl, .sts, .result
  );

  // finish settles the snap on the same edge, so build the result in a
  // second step: load it the cycle after finish
  logic load_d_r;
  always_ff @(posedge clk) begin
    if (!rst_n) load_d_r <= 1'b0;
    else load_d_r <= out_load;
  end
  always_ff @(posedge clk) begin
    if (load_d_r) out_data <= result;
  end

  `EPC_ASSERT(a_stall_busy, clk, rst_n, ctl.blend |-> in_stall, "input taken mid-blend")

endmodule

// ----- rtl/epc_datapath.sv -----
module epc_datapath #(
  parameter int PARAM_COUNT = epc_pkg::PARAM_COUNT_DEF,
  parameter int VALUE_BITS  = epc_pkg::VALUE_BITS_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  epc_pkg::in_item_t  item,
  input  epc_pkg::epc_cmd_t  ctl,
  output epc_pkg::epc_sts_t  sts,
  output epc_pkg::out_item_t result
);

  localparam int IW = (PARAM_COUNT > 1) ? $clog2(PARAM_COUNT) : 1;
  localparam int QB = epc_pkg::Q_BITS;
  localparam int DB = epc_pkg::DUR_BITS;
  localparam int NB = DB + 16;             // dividend: elapsed * 65536
  localparam int CB = $clog2(NB + 1);

  logic [VALUE_BITS-1:0] staged_r [PARAM_COUNT];
  logic [VALUE_BITS-1:0] from_r   [PARAM_COUNT];
  logic [VALUE_BITS-1:0] goal_r   [PARAM_COUNT];
  logic [VALUE_BITS-1:0] rend_r   [PARAM_COUNT];
  logic [DB-1:0] elapsed_r, len_r;
  logic          active_r, smooth_r, tick_r;

  logic [NB-1:0] quo_r;
  logic [DB:0]   rem_r;
  logic [CB-1:0] dcnt_r;
  logic          div_done_r;
  logic [QB-1:0] p_r, e_r;
  logic [2*QB-1:0] sq_r;
  logic [IW-1:0] bidx_r;

  // elapsed update on tick and duration clamp for start
  logic [DB:0] el_sum;
  logic [DB-1:0] dur_cl;
  always_comb begin
    el_sum = {1'b0, elapsed_r} + (DB+1)'(item.delta_ms);
    if (item.duration_ms == '0) dur_cl = DB'(1);
    else if (item.duration_ms > epc_pkg::MAX_FADE) dur_cl = epc_pkg::MAX_FADE;
    else dur_cl = item.duration_ms;
  end

  // restoring divider step
  logic [DB+1:0] rem_sh;
  logic [DB+1:0] rem_sub;
  always_comb begin
    rem_sh  = {rem_r, quo_r[NB-1]};
    rem_sub = rem_sh - {2'b00, len_r};
  end

  // ease multiply
  logic [QB+1:0] three_m2p;
  logic [3*QB+2:0] cube;
  always_comb begin
    three_m2p = (QB+2)'(3 * 65536) - {1'b0, p_r, 1'b0};
    cube = (3*QB+3)'(sq_r) * (3*QB+3)'(three_m2p);
  end

  // blend one parameter
  logic [VALUE_BITS-1:0] bf, bt, bd, bmag, bres;
  logic [VALUE_BITS+QB-1:0] bprod;
  logic bneg;
  always_comb begin
    bf = from_r[bidx_r];
    bt = goal_r[bidx_r];
    bd = bt - bf;
    if (bidx_r == '0) bneg = bd[VALUE_BITS-1];
    else bneg = bt < bf;
    bmag = bneg ? (bf - bt) : bd;
    bprod = (VALUE_BITS+QB)'(bmag) * (VALUE_BITS+QB)'(e_r);
    bres = bneg ? bf - bprod[VALUE_BITS+15:16] : bf + bprod[VALUE_BITS+15:16];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < PARAM_COUNT; i++) begin
        staged_r[i] <= '0;
        from_r[i]   <= '0;
        goal_r[i]   <= '0;
        rend_r[i]   <= '0;
      end
      elapsed_r  <= '0;
      len_r      <= DB'(1);
      active_r   <= 1'b0;
      smooth_r   <= 1'b0;
      tick_r     <= 1'b0;
      div_done_r <= 1'b0;
      dcnt_r     <= '0;
      bidx_r     <= '0;
      p_r        <= epc_pkg::Q_ONE;
      e_r        <= epc_pkg::Q_ONE;
    end else begin
      if (ctl.load) begin
        tick_r <= 1'b0;
        unique case (epc_pkg::cmd_t'(item.cmd))
          epc_pkg::CMD_STAGE: begin
            if (32'(item.param_index) < PARAM_COUNT)
              staged_r[item.param_index[IW-1:0]] <= item.param_value[VALUE_BITS-1:0];
          end
          epc_pkg::CMD_START: begin
            for (int i = 0; i < PARAM_COUNT; i++) begin
              from_r[i] <= rend_r[i];
              goal_r[i] <= staged_r[i];
            end
            elapsed_r <= '0;
            len_r     <= dur_cl;
            smooth_r  <= item.smooth_easing;
            active_r  <= 1'b1;
            e_r       <= '0;
          end
          epc_pkg::CMD_TICK: begin
            if (active_r) begin
              elapsed_r <= (el_sum > {1'b0, len_r}) ? len_r : el_sum[DB-1:0];
              tick_r    <= 1'b1;
            end
          end
          default: ;
        endcase
      end
      if (ctl.div_go) begin
        quo_r      <= {elapsed_r, 16'h0};
        rem_r      <= '0;
        dcnt_r     <= CB'(NB);
        div_done_r <= 1'b0;
      end else if (dcnt_r != '0) begin
        if (!rem_sub[DB+1]) begin
          rem_r <= rem_sub[DB:0];
          quo_r <= {quo_r[NB-2:0], 1'b1};
        end else begin
          rem_r <= rem_sh[DB:0];
          quo_r <= {quo_r[NB-2:0], 1'b0};
        end
        dcnt_r <= dcnt_r - CB'(1);
        if (dcnt_r == CB'(1)) div_done_r <= 1'b1;
      end
      if (div_done_r && !ctl.div_go && dcnt_r == '0 && !ctl.ease1) begin
        p_r <= (quo_r > NB'(epc_pkg::Q_ONE)) ? epc_pkg::Q_ONE : quo_r[QB-1:0];
        e_r <= (quo_r > NB'(epc_pkg::Q_ONE)) ? epc_pkg::Q_ONE : quo_r[QB-1:0];
        bidx_r <= '0;
        div_done_r <= 1'b0;
      end
      if (ctl.ease1) sq_r <= (2*QB)'(p_r) * (2*QB)'(p_r);
      if (ctl.ease2) e_r <= cube[QB+31:32];
      if (ctl.blend) begin
        rend_r[bidx_r] <= bres;
        if (32'(bidx_r) != PARAM_COUNT - 1) bidx_r <= bidx_r + IW'(1);
        else bidx_r <= '0;
      end
      if (ctl.finish && tick_r && elapsed_r >= len_r) begin
        for (int i = 0; i < PARAM_COUNT; i++) rend_r[i] <= goal_r[i];
        active_r <= 1'b0;
      end
    end
  end

  // p is taken from the divider the cycle after div_done rises
  logic div_seen_r;
  always_ff @(posedge clk) begin
    if (!rst_n) div_seen_r <= 1'b0;
    else div_seen_r <= div_done_r && dcnt_r == '0 && !ctl.div_go;
  end

  assign sts.is_tick    = tick_r;
  assign sts.div_done   = div_seen_r;
  assign sts.smooth     = smooth_r;
  assign sts.blend_last = (32'(bidx_r) == PARAM_COUNT - 1);

  // result reflects the register state; the top level samples it after finish
  logic [VALUE_BITS-1:0] shown [9];
  always_comb begin
    for (int i = 0; i < 9; i++) begin
      if (i < PARAM_COUNT) shown[i] = rend_r[i];
      else shown[i] = '0;
    end
    result.hue_offset     = 16'(shown[0]);
    result.hue_spread     = 16'(shown[1]);
    result.saturation     = 16'(shown[2]);
    result.lightness      = 16'(shown[3]);
    result.speed          = 16'(shown[4]);
    result.density        = 16'(shown[5]);
    result.scale_value    = 16'(shown[6]);
    result.wobble         = 16'(shown[7]);
    result.shape_value    = 16'(shown[8]);
    result.fading         = active_r;
    result.eased_progress = active_r ? e_r : epc_pkg::Q_ONE;
  end

endmodule

// ----- rtl/epc_ctrl.sv -----
`include "eased_parameter_crossfader_assert.svh"
module epc_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  output logic               out_valid,
  input  logic               out_stall,
  input  epc_pkg::epc_sts_t  sts,
  output epc_pkg::epc_cmd_t  ctl,
  output logic               out_load
);

  epc_pkg::state_t state_r, state_nxt;
  logic out_valid_r;
  logic out_load_d_r;
  logic free;
  // ST_DONE is visited right after load; an active tick then needs the arithmetic pass
  logic finish_seen_r;

  // result register may be refilled when empty or being drained
  assign free = !out_valid_r || !out_stall;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      epc_pkg::ST_IDLE:  if (in_valid) state_nxt = epc_pkg::ST_DONE;
      epc_pkg::ST_DIV:   if (sts.div_done)
                           state_nxt = sts.smooth ? epc_pkg::ST_EASE1 : epc_pkg::ST_BLEND;
      epc_pkg::ST_EASE1: state_nxt = epc_pkg::ST_EASE2;
      epc_pkg::ST_EASE2: state_nxt = epc_pkg::ST_BLEND;
      epc_pkg::ST_BLEND: if (sts.blend_last) state_nxt = epc_pkg::ST_DONE;
      epc_pkg::ST_DONE:  begin
        if (sts.is_tick && !finish_seen_r) state_nxt = epc_pkg::ST_DIV;
        else if (free) state_nxt = epc_pkg::ST_IDLE;
      end
      default:           state_nxt = epc_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    ctl = '0;
    out_load = 1'b0;
    unique case (state_r)
      epc_pkg::ST_IDLE:  ctl.load = in_valid;
      epc_pkg::ST_DIV:   ;
      epc_pkg::ST_EASE1: ctl.ease1 = 1'b1;
      epc_pkg::ST_EASE2: ctl.ease2 = 1'b1;
      epc_pkg::ST_BLEND: ctl.blend = 1'b1;
      epc_pkg::ST_DONE:  begin
        if (sts.is_tick && !finish_seen_r) ctl.div_go = 1'b1;
        else if (free) begin
          ctl.finish = 1'b1;
          out_load   = 1'b1;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= epc_pkg::ST_IDLE;
      out_valid_r   <= 1'b0;
      out_load_d_r  <= 1'b0;
      finish_seen_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      out_load_d_r <= out_load;
      if (ctl.load) finish_seen_r <= 1'b0;
      else if (state_r == epc_pkg::ST_BLEND && sts.blend_last) finish_seen_r <= 1'b1;
      // the result register fills the cycle after finish; raise valid with it
      if (out_load_d_r) out_valid_r <= 1'b1;
      else if (!out_stall) out_valid_r <= 1'b0;
    end
  end

  assign in_stall  = (state_r != epc_pkg::ST_IDLE);
  assign out_valid = out_valid_r;

  `EPC_ASSERT(a_load_idle, clk, rst_n, ctl.load |-> state_r == epc_pkg::ST_IDLE, "load outside idle")
  `EPC_ASSERT(a_out_hold, clk, rst_n, (out_valid_r && out_stall) |-> !out_load, "result overwritten")
  `EPC_ASSERT(a_ease_seq, clk, rst_n, ctl.ease1 |=> ctl.ease2, "ease steps out of order")

endmodule
